// File: hdl/sdi_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helpers of the sampled data integrator
// no dependencies
package sdi_pkg;

	localparam int SEGMENT_POINTS = 8;
	localparam int GAUSS_NODES    = 4;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic signed [63:0] INT64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] INT64_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [63:0] ONE_Q30   = 64'sd1073741824;

	// right shift applied after a product, with rounding
	typedef enum logic [1:0] {
		SH_0,
		SH_14,
		SH_17,
		SH_30
	} shift_t;

	typedef enum logic [1:0] {
		STATUS_OK  = 2'd0,
		STATUS_SAT = 2'd1,
		STATUS_DUP = 2'd2
	} status_t;

	// classified request between front and back
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic               last;
		logic               close;
	} item_t;

	typedef struct packed {
		logic               start;
		shift_t             sh;
		logic signed [63:0] a;
		logic signed [63:0] b;
	} mul_req_t;

	typedef struct packed {
		logic               done;
		logic               sat;
		logic signed [63:0] value;
	} mul_rsp_t;

	typedef struct packed {
		logic               start;
		logic signed [63:0] num;
		logic signed [32:0] den;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic signed [63:0] quot;
	} div_rsp_t;

	function automatic logic signed [63:0] node_q30(input logic [1:0] j);
		logic signed [63:0] r;
		unique case (j)
			2'd0: r = 64'sd365051866;
			2'd1: r = -64'sd365051866;
			2'd2: r = 64'sd924638074;
			2'd3: r = -64'sd924638074;
		endcase
		return r;
	endfunction

	function automatic logic signed [63:0] weight_q30(input logic [1:0] j);
		logic signed [63:0] r;
		unique case (j)
			2'd0, 2'd1: r = 64'sd700235528;
			2'd2, 2'd3: r = 64'sd373506296;
		endcase
		return r;
	endfunction

	// {overflow, clamped sum}
	function automatic logic [64:0] sat_add(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [63:0] s;
		logic               ovf;
		s   = a + b;
		ovf = (a[63] == b[63]) && (s[63] != a[63]);
		if (ovf) begin
			s = a[63] ? INT64_MIN : INT64_MAX;
		end
		return {ovf, s};
	endfunction

endpackage

// File: hdl/sampled_data_integrator_top.sv
`timescale 1ns / 1ps
// Sampled data integrator: takes (x, y) samples in Q16.16 and on the sample marked last
// returns the saturating Q32.32 integral and a status code. Each sample first scans the
// points already held in its segment for a repeated abscissa. When a segment closes, or on
// the last sample of a set with more than one point, the sequencer integrates the n held
// points over 4 Gauss nodes: n*(n-1) basis ratios per node, each a quotient from the shared
// one-bit-per-cycle 64-bit divider followed by a product from the shared 64x64
// multiplier (four 32x32 partial products). Samples queue in a two-entry front queue while
// the back end computes, and the result sits in an output register so the next data set
// can start before it is popped.
// Depends on sdi_pkg, sdi_front, sdi_mul, sdi_div, sdi_back.
module sampled_data_integrator_top #(
	parameter int SEGMENT_POINTS = sdi_pkg::SEGMENT_POINTS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [31:0] x_value,
	input  logic signed [31:0] y_value,
	input  logic               last_sample,
	output logic               empty,
	input  logic               pop,
	output logic signed [63:0] integral,
	output logic [1:0]         status
);

	localparam int AW = $clog2(SEGMENT_POINTS);

	logic              q_valid, q_pop;
	sdi_pkg::item_t    q_item;
	logic [AW-1:0]     q_slot;
	sdi_pkg::mul_req_t mul_req;
	sdi_pkg::mul_rsp_t mul_rsp;
	sdi_pkg::div_req_t div_req;
	sdi_pkg::div_rsp_t div_rsp;

	sdi_front #(
		.SEGMENT_POINTS(SEGMENT_POINTS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.x_value     (x_value),
		.y_value     (y_value),
		.last_sample (last_sample),
		.q_valid     (q_valid),
		.q_pop       (q_pop),
		.q_item      (q_item),
		.q_slot      (q_slot)
	);

	sdi_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	sdi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	sdi_back #(
		.SEGMENT_POINTS(SEGMENT_POINTS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_item   (q_item),
		.q_slot   (q_slot),
		.mul_req  (mul_req),
		.mul_rsp  (mul_rsp),
		.div_req  (div_req),
		.div_rsp  (div_rsp),
		.empty    (empty),
		.pop      (pop),
		.integral (integral),
		.status   (status)
	);

endmodule

// File: hdl/sdi_front.sv
`timescale 1ns / 1ps
// front end: accepts samples, tags segment close and final, queues requests
// depends on sdi_pkg
module sdi_front #(
	parameter int SEGMENT_POINTS = sdi_pkg::SEGMENT_POINTS
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   push,
	output logic                                   full,
	input  logic signed [31:0]                     x_value,
	input  logic signed [31:0]                     y_value,
	input  logic                                   last_sample,
	output logic                                   q_valid,
	input  logic                                   q_pop,
	output sdi_pkg::item_t                         q_item,
	output logic [$clog2(SEGMENT_POINTS)-1:0]      q_slot
);

	localparam int AW = $clog2(SEGMENT_POINTS);
	localparam int PW = $clog2(sdi_pkg::QUEUE_DEPTH);

	sdi_pkg::item_t item_mem [sdi_pkg::QUEUE_DEPTH];
	logic [AW-1:0]  slot_mem [sdi_pkg::QUEUE_DEPTH];
	logic [PW-1:0]  wptr_q, rptr_q;
	logic [PW:0]    cnt_q;
	logic [AW-1:0]  slot_q;
	logic           accept, take, close;
	sdi_pkg::item_t item_in;

	assign full    = (cnt_q == (PW+1)'(sdi_pkg::QUEUE_DEPTH));
	assign q_valid = (cnt_q != '0);
	assign accept  = push && !full;
	assign take    = q_pop && q_valid;
	assign close   = (slot_q == AW'(SEGMENT_POINTS - 1));

	assign item_in.x     = x_value;
	assign item_in.y     = y_value;
	assign item_in.last  = last_sample;
	assign item_in.close = close;

	assign q_item = item_mem[rptr_q];
	assign q_slot = slot_mem[rptr_q];

	always_ff @(posedge clk) begin
		if (accept) begin
			item_mem[wptr_q] <= item_in;
			slot_mem[wptr_q] <= slot_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
			slot_q <= '0;
		end else begin
			if (accept) begin
				wptr_q <= wptr_q + 1'b1;
				// the closing point is carried as the first of the next segment
				if (last_sample) begin
					slot_q <= '0;
				end else if (close) begin
					slot_q <= AW'(1);
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end
			if (take) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (accept && !take) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (take && !accept) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: hdl/sdi_mul.sv
`timescale 1ns / 1ps
// shared 64x64 signed multiplier, four 32x32 partial products,
// rounds half away from zero at the shift and clamps to +-(2^63-1); uses sdi_pkg
module sdi_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  sdi_pkg::mul_req_t req,
	output sdi_pkg::mul_rsp_t rsp
);

	typedef enum logic [1:0] {M_IDLE, M_MUL, M_RND, M_OUT} mstate_t;

	mstate_t          state_q;
	logic [63:0]      ma_q, mb_q, pp_q;
	logic [127:0]     acc_q, pp_ext, shifted, rnd;
	logic             neg_q;
	sdi_pkg::shift_t  sh_q;
	logic [2:0]       cnt_q;
	logic [1:0]       off_q;
	logic [31:0]      pa, pb;
	logic [63:0]      mag;
	logic             sat;

	assign pa = cnt_q[1] ? ma_q[63:32] : ma_q[31:0];
	assign pb = cnt_q[0] ? mb_q[63:32] : mb_q[31:0];

	always_comb begin
		unique case (off_q)
			2'd0:    pp_ext = {64'd0, pp_q};
			2'd1:    pp_ext = {32'd0, pp_q, 32'd0};
			default: pp_ext = {pp_q, 64'd0};
		endcase
		unique case (sh_q)
			sdi_pkg::SH_0:  begin rnd = 128'd0;        shifted = acc_q;       end
			sdi_pkg::SH_14: begin rnd = 128'd1 << 13;  shifted = acc_q >> 14; end
			sdi_pkg::SH_17: begin rnd = 128'd1 << 16;  shifted = acc_q >> 17; end
			sdi_pkg::SH_30: begin rnd = 128'd1 << 29;  shifted = acc_q >> 30; end
		endcase
		sat = |shifted[127:63];
		mag = shifted[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= M_IDLE;
			ma_q      <= '0;
			mb_q      <= '0;
			pp_q      <= '0;
			acc_q     <= '0;
			neg_q     <= 1'b0;
			sh_q      <= sdi_pkg::SH_0;
			cnt_q     <= '0;
			off_q     <= '0;
			rsp       <= '0;
		end else begin
			rsp.done <= 1'b0;
			unique case (state_q)
				M_IDLE: begin
					if (req.start) begin
						ma_q    <= req.a[63] ? 64'd0 - req.a : req.a;
						mb_q    <= req.b[63] ? 64'd0 - req.b : req.b;
						neg_q   <= req.a[63] ^ req.b[63];
						sh_q    <= req.sh;
						cnt_q   <= '0;
						acc_q   <= '0;
						state_q <= M_MUL;
					end
				end
				M_MUL: begin
					// product of one step is accumulated in the next
					if (cnt_q != 3'd4) begin
						pp_q  <= pa * pb;
						off_q <= 2'(cnt_q[1]) + 2'(cnt_q[0]);
					end
					if (cnt_q != 3'd0) begin
						acc_q <= acc_q + pp_ext;
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 3'd4) begin
						state_q <= M_RND;
					end
				end
				M_RND: begin
					acc_q   <= acc_q + rnd;
					state_q <= M_OUT;
				end
				M_OUT: begin
					rsp.done <= 1'b1;
					rsp.sat  <= sat;
					if (sat) begin
						rsp.value <= neg_q ? -sdi_pkg::INT64_MAX : sdi_pkg::INT64_MAX;
					end else begin
						rsp.value <= neg_q ? 64'd0 - mag : mag;
					end
					state_q <= M_IDLE;
				end
			endcase
		end
	end

endmodule

// File: hdl/sdi_div.sv
`timescale 1ns / 1ps
// signed 64 by 33 bit divider, one quotient bit per cycle, truncates toward zero
// depends on sdi_pkg
module sdi_div (
	input  logic              clk,
	input  logic              arst_n,
	input  sdi_pkg::div_req_t req,
	output sdi_pkg::div_rsp_t rsp
);

	typedef enum logic [1:0] {D_IDLE, D_RUN, D_OUT} dstate_t;

	dstate_t     state_q;
	logic [63:0] nm_q;
	logic [32:0] dm_q, rem_q;
	logic        neg_q;
	logic [5:0]  cnt_q;
	logic [33:0] trial, diff;
	logic        ge;

	assign trial = {rem_q, nm_q[63]};
	assign diff  = trial - {1'b0, dm_q};
	assign ge    = (trial >= {1'b0, dm_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			nm_q    <= '0;
			dm_q    <= '0;
			rem_q   <= '0;
			neg_q   <= 1'b0;
			cnt_q   <= '0;
			rsp     <= '0;
		end else begin
			rsp.done <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					if (req.start) begin
						nm_q    <= req.num[63] ? 64'd0 - req.num : req.num;
						dm_q    <= req.den[32] ? 33'd0 - req.den : req.den;
						neg_q   <= req.num[63] ^ req.den[32];
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					rem_q <= ge ? diff[32:0] : trial[32:0];
					nm_q  <= {nm_q[62:0], ge};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 6'd63) begin
						state_q <= D_OUT;
					end
				end
				D_OUT: begin
					rsp.done <= 1'b1;
					rsp.quot <= neg_q ? 64'd0 - nm_q : nm_q;
					state_q  <= D_IDLE;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

endmodule

// File: hdl/sdi_back.sv
`timescale 1ns / 1ps
// back end: point buffers, repeated abscissa scan, segment sequencer and result register
// depends on sdi_pkg; drives the shared sdi_mul and sdi_div units
module sdi_back #(
	parameter int SEGMENT_POINTS = sdi_pkg::SEGMENT_POINTS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	output logic                              q_pop,
	input  sdi_pkg::item_t                    q_item,
	input  logic [$clog2(SEGMENT_POINTS)-1:0] q_slot,
	output sdi_pkg::mul_req_t                 mul_req,
	input  sdi_pkg::mul_rsp_t                 mul_rsp,
	output sdi_pkg::div_req_t                 div_req,
	input  sdi_pkg::div_rsp_t                 div_rsp,
	output logic                              empty,
	input  logic                              pop,
	output logic signed [63:0]                integral,
	output logic [1:0]                        status
);

	localparam int AW = $clog2(SEGMENT_POINTS);

	typedef enum logic [4:0] {
		S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_DECIDE, S_A, S_NODE, S_NODE_W,
		S_K, S_K_W, S_I, S_I_W, S_DIV, S_BAS, S_Y, S_Y_W, S_TERM,
		S_W, S_WACC, S_SEG, S_SEG_W, S_POST, S_EMIT
	} state_t;

	state_t             state_q;
	logic signed [31:0] x_mem [SEGMENT_POINTS];
	logic signed [31:0] y_mem [SEGMENT_POINTS];
	logic signed [31:0] x_rd_q, y_rd_q;
	logic [AW-1:0]      rd_addr, wr_addr;
	logic               mem_we;
	logic signed [31:0] wr_x, wr_y;

	logic signed [31:0] cur_x_q, cur_y_q, xk_q;
	logic [AW-1:0]      cur_slot_q, i_q, k_q;
	logic               cur_last_q, cur_close_q, dup_q;
	logic signed [32:0] d_q, s_q;
	logic signed [46:0] p_q;
	logic [1:0]         j_q;
	logic signed [63:0] basis_q, f_q, acc_q, total_q;
	logic [1:0]         flags_q;
	logic               res_valid_q;

	logic signed [63:0] node_v, num_full, add_a, add_sum;
	logic signed [32:0] den;
	logic               add_ovf, seg_needed;

	assign q_pop = (state_q == S_IDLE) && q_valid;
	assign empty = !res_valid_q;

	// buffer write: new point, or the closing point carried to the front
	always_comb begin
		mem_we  = q_pop || (state_q == S_POST && cur_close_q);
		wr_addr = q_pop ? q_slot : '0;
		wr_x    = q_pop ? q_item.x : cur_x_q;
		wr_y    = q_pop ? q_item.y : cur_y_q;
		unique case (state_q)
			S_SCAN_RD, S_I: rd_addr = i_q;
			S_K, S_Y:       rd_addr = k_q;
			default:        rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			x_mem[wr_addr] <= wr_x;
			y_mem[wr_addr] <= wr_y;
		end
		x_rd_q <= x_mem[rd_addr];
		y_rd_q <= y_mem[rd_addr];
	end

	always_comb begin
		// evaluation point, 14 extra fraction bits, rounded half up
		node_v   = ({{31{s_q[32]}}, s_q} <<< 30) + mul_rsp.value + 64'sd65536;
		num_full = {{17{p_q[46]}}, p_q} - ({{32{x_rd_q[31]}}, x_rd_q} <<< 14);
		den      = {xk_q[31], xk_q} - {x_rd_q[31], x_rd_q};
		unique case (state_q)
			S_TERM:  add_a = f_q;
			S_WACC:  add_a = acc_q;
			default: add_a = total_q;
		endcase
		{add_ovf, add_sum} = sdi_pkg::sat_add(add_a, mul_rsp.value);
		seg_needed = cur_close_q || (cur_last_q && cur_slot_q != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			cur_slot_q  <= '0;
			cur_last_q  <= 1'b0;
			cur_close_q <= 1'b0;
			dup_q       <= 1'b0;
			xk_q        <= '0;
			i_q         <= '0;
			k_q         <= '0;
			j_q         <= '0;
			d_q         <= '0;
			s_q         <= '0;
			p_q         <= '0;
			basis_q     <= '0;
			f_q         <= '0;
			acc_q       <= '0;
			total_q     <= '0;
			flags_q     <= '0;
			res_valid_q <= 1'b0;
			integral    <= '0;
			status      <= '0;
			mul_req     <= '0;
			div_req     <= '0;
		end else begin
			mul_req.start <= 1'b0;
			div_req.start <= 1'b0;
			// in S_EMIT a pop is folded into the result register load
			if (pop && res_valid_q && state_q != S_EMIT) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						cur_x_q     <= q_item.x;
						cur_y_q     <= q_item.y;
						cur_last_q  <= q_item.last;
						cur_close_q <= q_item.close;
						cur_slot_q  <= q_slot;
						i_q         <= '0;
						state_q     <= S_SCAN_RD;
					end
				end
				S_SCAN_RD: begin
					state_q <= (i_q == cur_slot_q) ? S_DECIDE : S_SCAN_CMP;
				end
				S_SCAN_CMP: begin
					if (x_rd_q == cur_x_q) begin
						dup_q <= 1'b1;
					end
					i_q     <= i_q + 1'b1;
					state_q <= S_SCAN_RD;
				end
				S_DECIDE: begin
					if (!seg_needed) begin
						state_q <= S_POST;
					end else if (dup_q) begin
						flags_q[1] <= 1'b1;
						state_q    <= S_POST;
					end else begin
						j_q     <= '0;
						acc_q   <= '0;
						state_q <= S_A;
					end
				end
				S_A: begin
					d_q     <= {cur_x_q[31], cur_x_q} - {x_rd_q[31], x_rd_q};
					s_q     <= {cur_x_q[31], cur_x_q} + {x_rd_q[31], x_rd_q};
					state_q <= S_NODE;
				end
				S_NODE: begin
					mul_req.start <= 1'b1;
					mul_req.sh    <= sdi_pkg::SH_0;
					mul_req.a     <= {{31{d_q[32]}}, d_q};
					mul_req.b     <= sdi_pkg::node_q30(j_q);
					state_q       <= S_NODE_W;
				end
				S_NODE_W: begin
					if (mul_rsp.done) begin
						p_q     <= node_v[63:17];
						f_q     <= '0;
						k_q     <= '0;
						state_q <= S_K;
					end
				end
				S_K: begin
					state_q <= S_K_W;
				end
				S_K_W: begin
					xk_q    <= x_rd_q;
					basis_q <= sdi_pkg::ONE_Q30;
					i_q     <= '0;
					state_q <= S_I;
				end
				S_I: begin
					if (i_q == k_q) begin
						if (i_q == cur_slot_q) begin
							state_q <= S_Y;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end else begin
						state_q <= S_I_W;
					end
				end
				S_I_W: begin
					div_req.start <= 1'b1;
					div_req.num   <= {num_full[47:0], 16'd0};
					div_req.den   <= den;
					state_q       <= S_DIV;
				end
				S_DIV: begin
					if (div_rsp.done) begin
						mul_req.start <= 1'b1;
						mul_req.sh    <= sdi_pkg::SH_30;
						mul_req.a     <= basis_q;
						mul_req.b     <= div_rsp.quot;
						state_q       <= S_BAS;
					end
				end
				S_BAS: begin
					if (mul_rsp.done) begin
						basis_q <= mul_rsp.value;
						if (mul_rsp.sat) begin
							flags_q[0] <= 1'b1;
						end
						if (i_q == cur_slot_q) begin
							state_q <= S_Y;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= S_I;
						end
					end
				end
				S_Y: begin
					state_q <= S_Y_W;
				end
				S_Y_W: begin
					mul_req.start <= 1'b1;
					mul_req.sh    <= sdi_pkg::SH_14;
					mul_req.a     <= {{32{y_rd_q[31]}}, y_rd_q};
					mul_req.b     <= basis_q;
					state_q       <= S_TERM;
				end
				S_TERM: begin
					if (mul_rsp.done) begin
						f_q <= add_sum;
						if (mul_rsp.sat || add_ovf) begin
							flags_q[0] <= 1'b1;
						end
						if (k_q == cur_slot_q) begin
							state_q <= S_W;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_K;
						end
					end
				end
				S_W: begin
					mul_req.start <= 1'b1;
					mul_req.sh    <= sdi_pkg::SH_30;
					mul_req.a     <= f_q;
					mul_req.b     <= sdi_pkg::weight_q30(j_q);
					state_q       <= S_WACC;
				end
				S_WACC: begin
					if (mul_rsp.done) begin
						acc_q <= add_sum;
						if (mul_rsp.sat || add_ovf) begin
							flags_q[0] <= 1'b1;
						end
						if (j_q == 2'(sdi_pkg::GAUSS_NODES - 1)) begin
							state_q <= S_SEG;
						end else begin
							j_q     <= j_q + 1'b1;
							state_q <= S_NODE;
						end
					end
				end
				S_SEG: begin
					mul_req.start <= 1'b1;
					mul_req.sh    <= sdi_pkg::SH_17;
					mul_req.a     <= acc_q;
					mul_req.b     <= {{31{d_q[32]}}, d_q};
					state_q       <= S_SEG_W;
				end
				S_SEG_W: begin
					if (mul_rsp.done) begin
						total_q <= add_sum;
						if (mul_rsp.sat || add_ovf) begin
							flags_q[0] <= 1'b1;
						end
						state_q <= S_POST;
					end
				end
				S_POST: begin
					if (cur_close_q) begin
						dup_q <= 1'b0;
					end
					state_q <= cur_last_q ? S_EMIT : S_IDLE;
				end
				S_EMIT: begin
					if (!res_valid_q || pop) begin
						res_valid_q <= 1'b1;
						integral    <= total_q;
						if (flags_q[1]) begin
							status <= sdi_pkg::STATUS_DUP;
						end else if (flags_q[0]) begin
							status <= sdi_pkg::STATUS_SAT;
						end else begin
							status <= sdi_pkg::STATUS_OK;
						end
						total_q <= '0;
						flags_q <= '0;
						dup_q   <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: verif/sampled_data_integrator_top_test.sv
`timescale 1ns / 1ps
// testbench for sampled_data_integrator_top: random and directed sample sets,
// a bit-accurate integral predictor and a result scoreboard
// depends on sdi_pkg and the integrator rtl
module sampled_data_integrator_top_test;

	localparam longint SAT_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint SAT_MIN   = 64'sh8000_0000_0000_0000;
	localparam longint UNIT_Q30  = 64'sd1073741824;
	localparam int     SEG_LEN   = 8;
	localparam int     N_ITEMS   = 1900;

	typedef enum int {SET_RAMP, SET_NOISE, SET_REPEAT} set_kind_t;

	typedef struct {
		int x;
		int y;
		bit last;
	} sample_t;

	typedef struct {
		longint           value;
		sdi_pkg::status_t code;
	} sum_t;

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	logic signed [31:0] x_value;
	logic signed [31:0] y_value;
	logic               last_sample;
	logic               empty;
	logic               pop;
	logic signed [63:0] integral;
	logic [1:0]         status;

	sampled_data_integrator_top u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.x_value(x_value), .y_value(y_value), .last_sample(last_sample),
		.empty(empty), .pop(pop), .integral(integral), .status(status)
	);

	always #5 clk = ~clk;

	// gauss nodes and weights, Q2.30
	const longint gauss_node[4]   = '{365051866, -365051866, 924638074, -924638074};
	const longint gauss_weight[4] = '{700235528, 700235528, 373506296, 373506296};

	// predictor state
	int       seg_x[SEG_LEN];
	int       seg_y[SEG_LEN];
	int       seg_fill;
	longint   run_total;
	logic [1:0] run_flags;

	sample_t  pending_samples[$];
	sum_t     expected_sums[$];
	int       n_errors;
	int       n_samples_sent;
	int       n_sums_seen;
	int       n_sat_seen;
	int       n_dup_seen;
	int       sample_gap;
	int       pop_gap;
	int       pop_hold;
	bit       tx_idle_on;
	bit       rx_idle_on;
	sample_t  cur;

	function automatic longint add_clamp(longint a, longint b);
		longint r;
		r = a + b;
		if (a[63] == b[63] && r[63] != a[63]) begin
			run_flags[0] = 1'b1;
			r = a[63] ? SAT_MIN : SAT_MAX;
		end
		return r;
	endfunction

	// exact product, rounded half away from zero, symmetric clamp
	function automatic longint mul_round(longint a, longint b, int sh);
		logic         neg;
		logic [63:0]  ma, mb;
		logic [127:0] prod;
		neg = (a < 0) != (b < 0);
		ma = (a < 0) ? -a : a;
		mb = (b < 0) ? -b : b;
		prod = {64'd0, ma} * {64'd0, mb};
		if (sh > 0)
			prod = (prod + (128'd1 << (sh - 1))) >> sh;
		if (prod[127:63] != 0) begin
			run_flags[0] = 1'b1;
			return neg ? -SAT_MAX : SAT_MAX;
		end
		return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
	endfunction

	function automatic longint segment_integral(int cnt);
		int     i, j, k;
		longint a, b, d, s, p, f, acc, basis, num, den;
		acc = 0;
		if (cnt < 2)
			return 0;
		for (i = 0; i < cnt; i++)
			for (j = i + 1; j < cnt; j++)
				if (seg_x[i] == seg_x[j]) begin
					run_flags[1] = 1'b1;
					return 0;
				end
		a = seg_x[0];
		b = seg_x[cnt - 1];
		d = b - a;
		s = a + b;
		for (j = 0; j < 4; j++) begin
			p = (s * UNIT_Q30 + d * gauss_node[j] + 65536) >>> 17;
			f = 0;
			for (k = 0; k < cnt; k++) begin
				basis = UNIT_Q30;
				for (i = 0; i < cnt; i++) begin
					if (i != k) begin
						num = p - longint'(seg_x[i]) * 16384;
						den = longint'(seg_x[k]) - longint'(seg_x[i]);
						basis = mul_round(basis, (num * 65536) / den, 30);
					end
				end
				f = add_clamp(f, mul_round(longint'(seg_y[k]), basis, 14));
			end
			acc = add_clamp(acc, mul_round(f, gauss_weight[j], 30));
		end
		return mul_round(acc, d, 17);
	endfunction

	task automatic take_sample(int x, int y, bit last);
		sum_t r;
		seg_x[seg_fill] = x;
		seg_y[seg_fill] = y;
		seg_fill++;
		if (seg_fill >= SEG_LEN) begin
			run_total = add_clamp(run_total, segment_integral(SEG_LEN));
			seg_x[0] = seg_x[SEG_LEN - 1];
			seg_y[0] = seg_y[SEG_LEN - 1];
			seg_fill = 1;
		end
		if (last) begin
			run_total = add_clamp(run_total, segment_integral(seg_fill));
			r.value = run_total;
			r.code = run_flags[1] ? sdi_pkg::STATUS_DUP :
				(run_flags[0] ? sdi_pkg::STATUS_SAT : sdi_pkg::STATUS_OK);
			expected_sums.push_back(r);
			seg_fill = 0;
			run_total = 0;
			run_flags = 2'b00;
		end
	endtask

	task automatic report(string what, longint got, longint want);
		n_errors++;
		$display("mismatch on result %0d: %s got %0d expected %0d", n_sums_seen, what,
			got, want);
	endtask

	task automatic queue_sample(int x, int y, bit last);
		sample_t s;
		s.x = x;
		s.y = y;
		s.last = last;
		pending_samples.push_back(s);
	endtask

	// one data set of n samples, closed by a last flag
	task automatic queue_set(int n, set_kind_t kind);
		int xs, step, y, i, rep;
		bit small_y;
		xs = $signed($urandom) >>> 2;
		step = 1 << $urandom_range(4, 24);
		small_y = $urandom_range(0, 1);
		rep = $urandom_range(1, (n > 1) ? n - 1 : 1);
		for (i = 0; i < n; i++) begin
			y = small_y ? int'($urandom_range(0, 1 << 20)) - (1 << 19) : int'($urandom);
			if (kind == SET_NOISE)
				xs = int'($urandom);
			else if (i > 0 && !(kind == SET_REPEAT && i == rep))
				xs = xs + $urandom_range(1, step);
			queue_sample(xs, y, i == n - 1);
		end
	endtask

	// sender: one request per accepted sample
	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full) begin
				take_sample(x_value, y_value, last_sample);
				n_samples_sent++;
				if ($urandom_range(0, 99) == 0)
					tx_idle_on = !tx_idle_on;
				sample_gap = tx_idle_on ? $urandom_range(0, 19) : 0;
			end
			if (push && full) begin
				push <= 1'b1;
			end else if (sample_gap > 0) begin
				sample_gap--;
				push <= 1'b0;
			end else if (pending_samples.size() > 0) begin
				cur = pending_samples.pop_front();
				push <= 1'b1;
				x_value <= cur.x;
				y_value <= cur.y;
				last_sample <= cur.last;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// receiver: check each popped integral against the oldest prediction
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_sums.size() == 0) begin
					report("unexpected integral", integral, 0);
				end else begin
					if (integral !== expected_sums[0].value)
						report("integral", integral, expected_sums[0].value);
					if (status !== expected_sums[0].code)
						report("status", status, expected_sums[0].code);
					void'(expected_sums.pop_front());
				end
				if (status == sdi_pkg::STATUS_SAT)
					n_sat_seen++;
				if (status == sdi_pkg::STATUS_DUP)
					n_dup_seen++;
				n_sums_seen++;
				// long hold-off so the sender backs up against a full block
				if (n_sums_seen == 20)
					pop_hold = 60000;
				if ($urandom_range(0, 29) == 0)
					rx_idle_on = !rx_idle_on;
				pop_gap = rx_idle_on ? $urandom_range(0, 19) : 0;
			end
			if (pop_hold > 0) begin
				pop_hold--;
				pop <= 1'b0;
			end else if (pop_gap > 0) begin
				pop_gap--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		int n, pick;
		clk = 1'b0;
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		x_value = '0;
		y_value = '0;
		last_sample = 1'b0;
		seg_fill = 0;
		run_total = 0;
		run_flags = 2'b00;
		n_errors = 0;
		n_samples_sent = 0;
		n_sums_seen = 0;
		n_sat_seen = 0;
		n_dup_seen = 0;
		sample_gap = 0;
		pop_gap = 0;
		pop_hold = 0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;

		// single point, constant line, full segment closing on the last flag
		queue_sample(0, 0, 1'b1);
		queue_sample(0, 1 << 16, 1'b0);
		queue_sample(1 << 16, 1 << 16, 1'b1);
		for (int i = 0; i < SEG_LEN; i++)
			queue_sample(i << 16, (i * i) << 14, i == SEG_LEN - 1);
		// repeated abscissa
		queue_sample(5 << 16, 7, 1'b0);
		queue_sample(5 << 16, -7, 1'b1);
		// field extremes, saturating spans
		queue_sample(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
		queue_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
		queue_sample(32'sh8000_0000, 32'sh8000_0000, 1'b0);
		queue_sample(-1, -1, 1'b0);
		queue_sample(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);

		while (pending_samples.size() < N_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 70)
				n = $urandom_range(1, 8);
			else if (pick < 95)
				n = $urandom_range(9, 15);
			else
				n = $urandom_range(16, 30);
			pick = $urandom_range(0, 99);
			queue_set(n, pick < 80 ? SET_RAMP : (pick < 92 ? SET_NOISE : SET_REPEAT));
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_samples.size() == 0 && !push);
		wait (expected_sums.size() == 0);
		repeat (200) @(posedge clk);
		$display("covered %0d samples in %0d data sets", n_samples_sent, n_sums_seen);
		$display("results flagged saturated %0d, repeated abscissa %0d", n_sat_seen,
			n_dup_seen);
		if (n_errors == 0)
			$display("sampled_data_integrator_top test passed");
		else
			$display("sampled_data_integrator_top test failed");
		$finish;
	end

	initial begin
		#400_000_000;
		$display("timeout with %0d results outstanding", expected_sums.size());
		$display("sampled_data_integrator_top test failed");
		$finish;
	end

endmodule

// File: filelist.f
hdl/sdi_pkg.sv
hdl/sdi_front.sv
hdl/sdi_mul.sv
hdl/sdi_div.sv
hdl/sdi_back.sv
hdl/sampled_data_integrator_top.sv
verif/sampled_data_integrator_top_test.sv
